// ===== sv/aphp_pkg.sv =====
// ---------------------------------------------------------------------------
// APDU header parser package
// Shared types, result codes and PDU type numbers for the header parser.
// ---------------------------------------------------------------------------
`default_nettype none

package aphp_pkg;

  typedef enum logic [1:0] {
    MODE_HEADER  = 2'd0,
    MODE_PAYLOAD = 2'd1,
    MODE_DROP    = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ROLE_CODES  = 3'd0,
    ROLE_INVOKE = 3'd1,
    ROLE_SEQ    = 3'd2,
    ROLE_WIN    = 3'd3,
    ROLE_SVC    = 3'd4
  } role_t;

  localparam logic [1:0] KIND_HEADER    = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD   = 2'd1;
  localparam logic [1:0] KIND_TRUNCATED = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN   = 2'd3;

  localparam logic [3:0] PDU_CONF_REQ   = 4'd0;
  localparam logic [3:0] PDU_UNCONF_REQ = 4'd1;
  localparam logic [3:0] PDU_CPLX_ACK   = 4'd3;
  localparam logic [3:0] PDU_SEG_ACK    = 4'd4;
  localparam logic [3:0] PDU_ERROR      = 4'd5;
  localparam logic [3:0] PDU_ABORT      = 4'd7;

  localparam logic [3:0] FLAG_SEG = 4'h8;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] pdu_type;
    logic [3:0] flags;
    logic [2:0] max_segs_code;
    logic [3:0] max_resp_code;
    logic [7:0] invoke_id;
    logic [7:0] seq_number;
    logic [7:0] window_size;
    logic [7:0] service_or_reason;
    logic [7:0] payload_byte;
    logic       last;
  } res_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } word_t;

  function automatic logic [3:0] flag_mask(input logic [3:0] pdu);
    logic [3:0] m;
    case (pdu)
      PDU_CONF_REQ: m = 4'hE;
      PDU_CPLX_ACK: m = 4'hC;
      PDU_SEG_ACK:  m = 4'h3;
      PDU_ABORT:    m = 4'h1;
      default:      m = 4'h0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== sv/apdu_header_parser_top.sv =====
// ---------------------------------------------------------------------------
// BACnet APDU header parser
// Decodes the header of a BACnet APDU presented one octet per word.
//
// The input channel carries one octet per word in in_byte, with in_last_byte
// marking the final octet of the APDU. The output channel gives at most one
// result word per input word: a header, a passed-through payload octet, a
// truncated header or an unknown type report, selected by out_kind.
// A word is accepted at a rising edge where valid is high and stall is low.
// One word is accepted every cycle when the receiver does not stall. A result
// passes through the input register and then the result register on its way
// to the output. The parser state advances once per accepted octet.
// When the receiver stalls, the result register holds its word, the parser
// stops, and in_stall rises once the input register is also occupied.
// Synchronous reset empties both registers and returns the parser to the
// first octet of a new APDU with all held header fields zero.
// ---------------------------------------------------------------------------
`default_nettype none

module apdu_header_parser_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_kind,
  output logic [3:0]      out_pdu_type,
  output logic [3:0]      out_flags,
  output logic [2:0]      out_max_segs_code,
  output logic [3:0]      out_max_resp_code,
  output logic [7:0]      out_invoke_id,
  output logic [7:0]      out_seq_number,
  output logic [7:0]      out_window_size,
  output logic [7:0]      out_service_or_reason,
  output logic [7:0]      out_payload_byte,
  output logic            out_last
);
  import aphp_pkg::*;

  word_t word;
  logic  load_ok;
  logic  fire;
  logic  res_valid;
  res_t  res;
  res_t  out_res;

  assign fire = word.valid && load_ok;

  aphp_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_byte      (in_byte),
    .in_last_byte (in_last_byte),
    .advance      (load_ok),
    .in_stall     (in_stall),
    .word         (word)
  );

  aphp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .word      (word),
    .res_valid (res_valid),
    .res       (res)
  );

  aphp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .res_valid (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_kind              = out_res.kind;
  assign out_pdu_type          = out_res.pdu_type;
  assign out_flags             = out_res.flags;
  assign out_max_segs_code     = out_res.max_segs_code;
  assign out_max_resp_code     = out_res.max_resp_code;
  assign out_invoke_id         = out_res.invoke_id;
  assign out_seq_number        = out_res.seq_number;
  assign out_window_size       = out_res.window_size;
  assign out_service_or_reason = out_res.service_or_reason;
  assign out_payload_byte      = out_res.payload_byte;
  assign out_last              = out_res.last;

endmodule

`default_nettype wire

// ===== sv/aphp_in_reg.sv =====
// ---------------------------------------------------------------------------
// APDU header parser input register
// Captures one input word and holds it while the result side is stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module aphp_in_reg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_last_byte,
  input  wire logic          advance,
  output logic               in_stall,
  output aphp_pkg::word_t    word
);
  import aphp_pkg::*;

  logic       valid_r;
  logic [7:0] data_r;
  logic       last_r;

  assign in_stall = valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      data_r <= in_byte;
      last_r <= in_last_byte;
    end
  end

  assign word = '{valid: valid_r, data: data_r, last: last_r};

endmodule

`default_nettype wire

// ===== sv/aphp_parser.sv =====
// ---------------------------------------------------------------------------
// APDU header parser core
// Holds the byte position and header fields and decodes one octet per cycle while not stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module aphp_parser (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          fire,
  input  wire aphp_pkg::word_t word,
  output logic               res_valid,
  output aphp_pkg::res_t     res
);
  import aphp_pkg::*;

  logic [2:0] pos_r,    pos_nxt;
  mode_t      mode_r,   mode_nxt;
  logic [3:0] type_r,   type_nxt;
  logic [3:0] flags_r,  flags_nxt;
  logic [2:0] segs_r,   segs_nxt;
  logic [3:0] resp_r,   resp_nxt;
  logic [7:0] invoke_r, invoke_nxt;
  logic [7:0] seq_r,    seq_nxt;
  logic [7:0] win_r,    win_nxt;

  role_t      role;
  logic       fin;
  logic       seg;
  logic [7:0] svc;
  logic [3:0] new_type;
  logic [3:0] u_flags;
  logic [2:0] u_segs;
  logic [3:0] u_resp;
  logic [7:0] u_invoke;
  logic [7:0] u_seq;
  logic [7:0] u_win;

  assign seg      = (flags_r & FLAG_SEG) != 4'h0;
  assign new_type = word.data[7:4];

  always_comb begin
    role = ROLE_SVC;
    fin  = 1'b0;
    case (type_r)
      PDU_CONF_REQ: begin
        if (pos_r == 3'd1) role = ROLE_CODES;
        else if (pos_r == 3'd2) role = ROLE_INVOKE;
        else if (seg && pos_r == 3'd3) role = ROLE_SEQ;
        else if (seg && pos_r == 3'd4) role = ROLE_WIN;
        else fin = 1'b1;
      end
      PDU_UNCONF_REQ: begin
        fin = 1'b1;
      end
      PDU_CPLX_ACK: begin
        if (pos_r == 3'd1) role = ROLE_INVOKE;
        else if (seg && pos_r == 3'd2) role = ROLE_SEQ;
        else if (seg && pos_r == 3'd3) role = ROLE_WIN;
        else fin = 1'b1;
      end
      PDU_SEG_ACK: begin
        if (pos_r == 3'd1) role = ROLE_INVOKE;
        else if (pos_r == 3'd2) role = ROLE_SEQ;
        else begin
          role = ROLE_WIN;
          fin  = 1'b1;
        end
      end
      default: begin
        if (pos_r == 3'd1) role = ROLE_INVOKE;
        else fin = 1'b1;
      end
    endcase
  end

  always_comb begin
    u_flags  = flags_r;
    u_segs   = segs_r;
    u_resp   = resp_r;
    u_invoke = invoke_r;
    u_seq    = seq_r;
    u_win    = win_r;
    svc      = 8'h00;
    case (role)
      ROLE_CODES: begin
        u_segs = word.data[6:4];
        u_resp = word.data[3:0];
      end
      ROLE_INVOKE: u_invoke = word.data;
      ROLE_SEQ:    u_seq    = word.data;
      ROLE_WIN:    u_win    = word.data;
      default:     svc      = word.data;
    endcase
  end

  always_comb begin
    pos_nxt    = pos_r;
    mode_nxt   = mode_r;
    type_nxt   = type_r;
    flags_nxt  = flags_r;
    segs_nxt   = segs_r;
    resp_nxt   = resp_r;
    invoke_nxt = invoke_r;
    seq_nxt    = seq_r;
    win_nxt    = win_r;
    res_valid  = 1'b0;
    res        = '0;
    res.last   = word.last;

    case (mode_r)
      MODE_PAYLOAD: begin
        res_valid        = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.pdu_type     = type_r;
        res.payload_byte = word.data;
      end
      MODE_DROP: begin
        res_valid = 1'b0;
      end
      default: begin
        if (pos_r == 3'd0) begin
          segs_nxt   = 3'd0;
          resp_nxt   = 4'd0;
          invoke_nxt = 8'h00;
          seq_nxt    = 8'h00;
          win_nxt    = 8'h00;
          if (new_type[3]) begin
            res_valid    = 1'b1;
            res.kind     = KIND_UNKNOWN;
            res.pdu_type = new_type;
            type_nxt     = new_type;
            flags_nxt    = 4'h0;
            mode_nxt     = MODE_DROP;
          end else begin
            type_nxt  = new_type;
            flags_nxt = word.data[3:0] & flag_mask(new_type);
            pos_nxt   = 3'd1;
            if (word.last) begin
              res_valid    = 1'b1;
              res.kind     = KIND_TRUNCATED;
              res.pdu_type = new_type;
              res.flags    = word.data[3:0] & flag_mask(new_type);
            end
          end
        end else begin
          segs_nxt   = u_segs;
          resp_nxt   = u_resp;
          invoke_nxt = u_invoke;
          seq_nxt    = u_seq;
          win_nxt    = u_win;
          pos_nxt    = pos_r + 3'd1;
          if (fin || word.last) begin
            res_valid         = 1'b1;
            res.kind          = fin ? KIND_HEADER : KIND_TRUNCATED;
            res.pdu_type      = type_r;
            res.flags         = u_flags;
            res.max_segs_code = u_segs;
            res.max_resp_code = u_resp;
            res.invoke_id     = u_invoke;
            res.seq_number    = u_seq;
            res.window_size   = u_win;
            res.service_or_reason = fin ? svc : 8'h00;
          end
          if (fin) begin
            pos_nxt = 3'd0;
            if (type_r == PDU_CONF_REQ || type_r == PDU_UNCONF_REQ ||
                type_r == PDU_CPLX_ACK || type_r == PDU_ERROR) begin
              mode_nxt = MODE_PAYLOAD;
            end else begin
              mode_nxt = MODE_DROP;
            end
          end
        end
      end
    endcase

    if (word.last) begin
      pos_nxt    = 3'd0;
      mode_nxt   = MODE_HEADER;
      type_nxt   = 4'd0;
      flags_nxt  = 4'd0;
      segs_nxt   = 3'd0;
      resp_nxt   = 4'd0;
      invoke_nxt = 8'h00;
      seq_nxt    = 8'h00;
      win_nxt    = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= 3'd0;
      mode_r   <= MODE_HEADER;
      type_r   <= 4'd0;
      flags_r  <= 4'd0;
      segs_r   <= 3'd0;
      resp_r   <= 4'd0;
      invoke_r <= 8'h00;
      seq_r    <= 8'h00;
      win_r    <= 8'h00;
    end else if (fire) begin
      pos_r    <= pos_nxt;
      mode_r   <= mode_nxt;
      type_r   <= type_nxt;
      flags_r  <= flags_nxt;
      segs_r   <= segs_nxt;
      resp_r   <= resp_nxt;
      invoke_r <= invoke_nxt;
      seq_r    <= seq_nxt;
      win_r    <= win_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/aphp_out_reg.sv =====
// ---------------------------------------------------------------------------
// APDU header parser output register
// Holds one result word until the receiver takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module aphp_out_reg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          fire,
  input  wire logic          res_valid,
  input  wire aphp_pkg::res_t res,
  input  wire logic          out_stall,
  output logic               load_ok,
  output logic               out_valid,
  output aphp_pkg::res_t     out_res
);
  import aphp_pkg::*;

  logic valid_r;
  res_t res_r;

  assign load_ok = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_ok) begin
      valid_r <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && fire && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// APDU header parser testbench
// Streams directed and random APDUs into the parser through a queue-fed
// driver, decodes every accepted octet in a local model of the parser, and
// checks each result word field by field against the oldest decoded word.
// Both sides idle at random, and the receiver also holds off once for a
// long stretch so that the parser backs up and stalls its input.
// ---------------------------------------------------------------------------

module tb;
  import aphp_pkg::*;

  typedef struct packed {
    logic [7:0] octet;
    logic       lst;
    logic       hold;
  } octet_item_t;

  localparam logic [8:0] DIRECTED_OCTETS [27] = '{
    9'h00F, 9'h075, 9'h0FF, 9'h000, 9'h0FF, 9'h00C, 9'h1AA,
    9'h01F, 9'h000, 9'h1FF,
    9'h020, 9'h001, 9'h10F,
    9'h043, 9'h012, 9'h034, 9'h105,
    9'h0F0, 9'h111, 9'h18F,
    9'h100,
    9'h03C, 9'h155,
    9'h071, 9'h009, 9'h022, 9'h133
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [3:0] out_pdu_type;
  logic [3:0] out_flags;
  logic [2:0] out_max_segs_code;
  logic [3:0] out_max_resp_code;
  logic [7:0] out_invoke_id;
  logic [7:0] out_seq_number;
  logic [7:0] out_window_size;
  logic [7:0] out_service_or_reason;
  logic [7:0] out_payload_byte;
  logic       out_last;

  octet_item_t octet_fifo[$];
  octet_item_t next_octet;
  res_t        decoded_words[$];
  res_t        oldest_word;

  logic [2:0] dec_pos;
  mode_t      dec_mode;
  logic [3:0] dec_type;
  logic [3:0] dec_flags;
  logic [2:0] dec_segs;
  logic [3:0] dec_resp;
  logic [7:0] dec_invoke;
  logic [7:0] dec_seq;
  logic [7:0] dec_win;

  int   mismatches = 0;
  int   octets_taken = 0;
  int   send_gap = 0;
  int   send_quiet = 0;
  int   stall_left = 0;
  int   recv_quiet = 0;
  logic long_hold = 1'b0;

  apdu_header_parser_top u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_byte               (in_byte),
    .in_last_byte          (in_last_byte),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_kind              (out_kind),
    .out_pdu_type          (out_pdu_type),
    .out_flags             (out_flags),
    .out_max_segs_code     (out_max_segs_code),
    .out_max_resp_code     (out_max_resp_code),
    .out_invoke_id         (out_invoke_id),
    .out_seq_number        (out_seq_number),
    .out_window_size       (out_window_size),
    .out_service_or_reason (out_service_or_reason),
    .out_payload_byte      (out_payload_byte),
    .out_last              (out_last)
  );

  always #5 clk = ~clk;

  function automatic logic [3:0] type_flag_bits(input logic [3:0] t);
    case (t)
      PDU_CONF_REQ: return 4'hE;
      PDU_CPLX_ACK: return 4'hC;
      PDU_SEG_ACK:  return 4'h3;
      PDU_ABORT:    return 4'h1;
      default:      return 4'h0;
    endcase
  endfunction

  function automatic logic carries_payload(input logic [3:0] t);
    return t == PDU_CONF_REQ || t == PDU_UNCONF_REQ || t == PDU_CPLX_ACK || t == PDU_ERROR;
  endfunction

  function automatic int header_octets(input logic [3:0] t, input logic seg);
    if (t[3]) return 1;
    case (t)
      PDU_CONF_REQ:   return seg ? 6 : 4;
      PDU_UNCONF_REQ: return 2;
      PDU_CPLX_ACK:   return seg ? 5 : 3;
      PDU_SEG_ACK:    return 4;
      default:        return 3;
    endcase
  endfunction

  function automatic int pick_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 199);
    if (r == 0) begin
      quiet = $urandom_range(40, 160);
      return 0;
    end
    if (r < 120) return 0;
    if (r < 180) return $urandom_range(1, 3);
    if (r < 196) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic clear_decoder();
    dec_pos = '0;
    dec_mode = MODE_HEADER;
    dec_type = '0;
    dec_flags = '0;
    dec_segs = '0;
    dec_resp = '0;
    dec_invoke = '0;
    dec_seq = '0;
    dec_win = '0;
  endtask

  function automatic res_t held_header(input logic [1:0] kind, input logic lst);
    res_t r;
    r = '0;
    r.kind = kind;
    r.pdu_type = dec_type;
    r.flags = dec_flags;
    r.max_segs_code = dec_segs;
    r.max_resp_code = dec_resp;
    r.invoke_id = dec_invoke;
    r.seq_number = dec_seq;
    r.window_size = dec_win;
    r.last = lst;
    return r;
  endfunction

  task automatic decode_octet(input logic [7:0] b, input logic lst);
    res_t  r;
    logic  fin;
    logic  seg;
    role_t role;
    r = '0;
    fin = 1'b0;
    if (dec_mode == MODE_PAYLOAD) begin
      r.kind = KIND_PAYLOAD;
      r.pdu_type = dec_type;
      r.payload_byte = b;
      r.last = lst;
      decoded_words.push_back(r);
      if (lst) clear_decoder();
    end else if (dec_mode == MODE_DROP) begin
      if (lst) clear_decoder();
    end else if (dec_pos == 3'd0) begin
      clear_decoder();
      dec_type = b[7:4];
      if (dec_type[3]) begin
        r.kind = KIND_UNKNOWN;
        r.pdu_type = dec_type;
        r.last = lst;
        decoded_words.push_back(r);
        if (lst) clear_decoder();
        else dec_mode = MODE_DROP;
      end else begin
        dec_flags = b[3:0] & type_flag_bits(dec_type);
        if (lst) begin
          decoded_words.push_back(held_header(KIND_TRUNCATED, 1'b1));
          clear_decoder();
        end else begin
          dec_pos = 3'd1;
        end
      end
    end else begin
      seg = (dec_flags & FLAG_SEG) != 4'h0;
      case (dec_type)
        PDU_CONF_REQ: begin
          if (dec_pos == 3'd1) role = ROLE_CODES;
          else if (dec_pos == 3'd2) role = ROLE_INVOKE;
          else if (seg && dec_pos == 3'd3) role = ROLE_SEQ;
          else if (seg && dec_pos == 3'd4) role = ROLE_WIN;
          else begin role = ROLE_SVC; fin = 1'b1; end
        end
        PDU_UNCONF_REQ: begin
          role = ROLE_SVC;
          fin = 1'b1;
        end
        PDU_CPLX_ACK: begin
          if (dec_pos == 3'd1) role = ROLE_INVOKE;
          else if (seg && dec_pos == 3'd2) role = ROLE_SEQ;
          else if (seg && dec_pos == 3'd3) role = ROLE_WIN;
          else begin role = ROLE_SVC; fin = 1'b1; end
        end
        PDU_SEG_ACK: begin
          if (dec_pos == 3'd1) role = ROLE_INVOKE;
          else if (dec_pos == 3'd2) role = ROLE_SEQ;
          else begin role = ROLE_WIN; fin = 1'b1; end
        end
        default: begin
          if (dec_pos == 3'd1) role = ROLE_INVOKE;
          else begin role = ROLE_SVC; fin = 1'b1; end
        end
      endcase
      case (role)
        ROLE_CODES: begin
          dec_segs = b[6:4];
          dec_resp = b[3:0];
        end
        ROLE_INVOKE: dec_invoke = b;
        ROLE_SEQ:    dec_seq = b;
        ROLE_WIN:    dec_win = b;
        default:     ;
      endcase
      if (fin) begin
        r = held_header(KIND_HEADER, lst);
        if (role == ROLE_SVC) r.service_or_reason = b;
        decoded_words.push_back(r);
        if (lst) begin
          clear_decoder();
        end else begin
          dec_pos = 3'd0;
          dec_mode = carries_payload(dec_type) ? MODE_PAYLOAD : MODE_DROP;
        end
      end else if (lst) begin
        decoded_words.push_back(held_header(KIND_TRUNCATED, 1'b1));
        clear_decoder();
      end else begin
        dec_pos = dec_pos + 3'd1;
      end
    end
  endtask

  task automatic add_octet(input logic [7:0] b, input logic lst, input logic hold);
    octet_item_t it;
    it.octet = b;
    it.lst = lst;
    it.hold = hold;
    octet_fifo.push_back(it);
  endtask

  // Mostly well-formed APDUs with random content, then truncated headers and noise.
  task automatic add_random_apdu(input logic hold, output int counted);
    logic [7:0] first;
    int         r;
    int         hl;
    int         len;
    r = $urandom_range(0, 99);
    first = $urandom_range(0, 255);
    if (r < 80) first[7] = 1'b0;
    hl = header_octets(first[7:4], first[3]);
    if (r < 70) begin
      len = hl + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 3));
    end else if (r < 80) begin
      len = $urandom_range(1, hl - 1);
    end else begin
      len = $urandom_range(1, 6);
    end
    counted = len;
    add_octet(first, len == 1, hold);
    for (int i = 1; i < len; i++) begin
      add_octet($urandom_range(0, 255), i == len - 1, 1'b0);
    end
  endtask

  task automatic report_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      clear_decoder();
    end else begin
      if (in_valid && !in_stall) begin
        decode_octet(in_byte, in_last_byte);
        octets_taken++;
        send_gap = pick_gap(send_quiet);
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (octet_fifo.size() != 0 &&
                     !(octet_fifo[0].hold && decoded_words.size() != 0)) begin
          next_octet = octet_fifo.pop_front();
          in_valid <= 1'b1;
          in_byte <= next_octet.octet;
          in_last_byte <= next_octet.lst;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (decoded_words.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual kind %0d", $time,
                   out_kind);
          mismatches++;
        end else begin
          oldest_word = decoded_words.pop_front();
          report_field("kind", oldest_word.kind, out_kind);
          report_field("pdu_type", oldest_word.pdu_type, out_pdu_type);
          report_field("flags", oldest_word.flags, out_flags);
          report_field("max_segs_code", oldest_word.max_segs_code, out_max_segs_code);
          report_field("max_resp_code", oldest_word.max_resp_code, out_max_resp_code);
          report_field("invoke_id", oldest_word.invoke_id, out_invoke_id);
          report_field("seq_number", oldest_word.seq_number, out_seq_number);
          report_field("window_size", oldest_word.window_size, out_window_size);
          report_field("service_or_reason", oldest_word.service_or_reason,
                       out_service_or_reason);
          report_field("payload_byte", oldest_word.payload_byte, out_payload_byte);
          report_field("last", oldest_word.last, out_last);
        end
      end
      if (stall_left > 0) stall_left--;
      else stall_left = pick_gap(recv_quiet);
      out_stall <= long_hold || (stall_left > 0);
    end
  end

  // One long receiver hold-off while the sender keeps offering words.
  initial begin
    wait (octets_taken >= 400);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (300) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int counted;
    int random_octets;
    random_octets = 0;
    foreach (DIRECTED_OCTETS[i]) begin
      add_octet(DIRECTED_OCTETS[i][7:0], DIRECTED_OCTETS[i][8], 1'b0);
    end
    add_random_apdu(1'b1, counted);
    random_octets += counted;
    while (random_octets < 1600) begin
      add_random_apdu($urandom_range(0, 149) == 0, counted);
      random_octets += counted;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (octet_fifo.size() != 0 || in_valid) @(posedge clk);
    while (decoded_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && decoded_words.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
